// ===== hw/rtl/gaussian_5x5_smoothing_macros.svh =====
// Assertion macros shared by the Gaussian smoothing RTL.
`ifndef GAUSSIAN_5X5_SMOOTHING_MACROS_SVH
`define GAUSSIAN_5X5_SMOOTHING_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define GS5_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gs5 same-cycle check failed");
// Next-cycle implication.
`define GS5_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gs5 next-cycle check failed");
`else
`define GS5_ASSERT_IMP(lbl, ante, cons)
`define GS5_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/gs5_pkg.sv =====
// Types, constants and kernel table for the 5x5 Gaussian smoothing block.
`default_nettype none
package gs5_pkg;

  localparam int GS5_MAX_WIDTH  = 2048;
  localparam int GS5_MAX_HEIGHT = 4096;
  localparam int KSIZE          = 5;

  localparam int PIXEL_W  = 8;
  localparam int SMOOTH_W = 16;
  localparam int CROW_W   = 12;
  localparam int CCOL_W   = 11;
  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 13;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  localparam int MIN_DIM       = 5;
  localparam int WIDTH_RESET   = 640;
  localparam int HEIGHT_RESET  = 480;

  // Row sums reach 49*255, the full sum 159*255.
  localparam int RS_W     = 14;
  localparam int SUM_W    = 16;
  localparam int SUM_MAX  = 159 * 255;
  localparam int SMOOTH_MAX = 65280;

  // floor((512*S + 159) / 318) equals floor((256*S + 79) / 159). The numerator is
  // then {S, 79} and the division is a multiply by ceil(2^32 / 159) and a shift.
  localparam int NUM_W       = SUM_W + 8;
  localparam logic [7:0] ROUND_LSB = 8'd79;
  localparam int RECIP_W     = 25;
  localparam logic [RECIP_W-1:0] RECIP = 25'd27012373;
  localparam int RECIP_SHIFT = 32;
  localparam int PROD_W      = NUM_W + RECIP_W;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [PIXEL_W-1:0] pix_t;
  // Row 0 is the oldest row, column 0 the leftmost column.
  typedef logic [KSIZE-1:0][KSIZE-1:0][PIXEL_W-1:0] win_t;

  typedef struct packed {
    logic              last;
    logic [CCOL_W-1:0] ccol;
    logic [CROW_W-1:0] crow;
  } meta_t;

  typedef logic [KSIZE-1:0][KSIZE-1:0][3:0] kern_t;
  localparam kern_t KERNEL = '{
    '{4'd2, 4'd4, 4'd5,  4'd4, 4'd2},
    '{4'd4, 4'd9, 4'd12, 4'd9, 4'd4},
    '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
    '{4'd4, 4'd9, 4'd12, 4'd9, 4'd4},
    '{4'd2, 4'd4, 4'd5,  4'd4, 4'd2}
  };

endpackage
`default_nettype wire

// ===== hw/rtl/gs5_ram.sv =====
// Generic single-port RAM with registered, read-first output.
`default_nettype none
module gs5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gs5_kernel.sv =====
// Weighted 5x5 sum and rounded division by 159 over three pipeline stages.
`default_nettype none
`include "gaussian_5x5_smoothing_macros.svh"
module gs5_kernel
  import gs5_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire win_t                in_win,
  input  wire meta_t               in_meta,
  output logic                     out_valid,
  output logic [SMOOTH_W-1:0]      out_smoothed,
  output meta_t                    out_meta
);

  logic [RS_W-1:0]   rs_nxt [KSIZE];
  logic [RS_W-1:0]   rs3_r  [KSIZE];
  logic              v3_r;
  meta_t             m3_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [SUM_W-1:0]  sum4_r;
  logic              v4_r;
  meta_t             m4_r;
  logic [NUM_W-1:0]  num4;
  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] prod5_r;
  logic              v5_r;
  meta_t             m5_r;

  // Constant weights, so each product is a few shifted adds.
  always_comb begin
    for (int i = 0; i < KSIZE; i++) begin
      rs_nxt[i] = '0;
      for (int j = 0; j < KSIZE; j++) begin
        rs_nxt[i] = rs_nxt[i] + RS_W'(KERNEL[i][j]) * RS_W'(in_win[i][j]);
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < KSIZE; i++) begin
      sum_nxt = sum_nxt + SUM_W'(rs3_r[i]);
    end
  end

  assign num4     = {sum4_r, ROUND_LSB};
  assign prod_nxt = PROD_W'(num4) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v3_r <= in_valid;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_valid) begin
        rs3_r <= rs_nxt;
        m3_r  <= in_meta;
      end
      if (v3_r) begin
        sum4_r <= sum_nxt;
        m4_r   <= m3_r;
      end
      if (v4_r) begin
        prod5_r <= prod_nxt;
        m5_r    <= m4_r;
      end
    end
  end

  assign out_valid    = v5_r;
  assign out_smoothed = prod5_r[RECIP_SHIFT +: SMOOTH_W];
  assign out_meta     = m5_r;

  `GS5_ASSERT_IMP(a_sum_range, v4_r, sum4_r <= SUM_W'(SUM_MAX))
  `GS5_ASSERT_IMP(a_result_range, v5_r, out_smoothed <= SMOOTH_W'(SMOOTH_MAX))
  `GS5_ASSERT_NXT(a_stage_flow, en && v4_r, v5_r)

endmodule
`default_nettype wire

// ===== hw/rtl/gaussian_5x5_smoothing.sv =====
// Top level of the 5x5 Gaussian smoothing block: position, line stores, window, output.
//
//   channel  | direction | handshake            | payload
//   in_      | slave     | in_tvalid/in_tready  | pixel in tdata, frame_start in tuser
//   out_     | master    | out_tvalid/out_tready| smoothed, center_row, center_col, last
//   cfg_     | APB slave | psel/penable/pready  | image_width at 0x0, image_height at 0x4
//
// One pixel item is taken per clock while in_tready is high.
// The rate is set by the four single-port line RAMs; each is read once per item, one is written.
// Reset is synchronous; no clearing pass is run, the line RAMs are filled by the stream.
// A stalled output fills a one-item skid register, and only then in_tready drops.
`default_nettype none
`include "gaussian_5x5_smoothing_macros.svh"
module gaussian_5x5_smoothing
  import gs5_pkg::*;
#(
  parameter int MAX_WIDTH  = GS5_MAX_WIDTH,
  parameter int MAX_HEIGHT = GS5_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [7:0] pixel
  input  wire logic [0:0]            in_tuser,   // [0] frame_start
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [39:0]                out_tdata,  // [15:0] smoothed, [27:16] center_row,
                                                 // [38:28] center_col, [39] zero
  output logic                       out_tlast,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WU_W  = (COL_W + 1 > CFG_WIDTH_W) ? COL_W + 1 : CFG_WIDTH_W;
  localparam int HU_W  = (ROW_W + 1 > CFG_HEIGHT_W) ? ROW_W + 1 : CFG_HEIGHT_W;
  localparam int NSLOT = KSIZE - 1;

  // Configuration
  logic [CFG_WIDTH_W-1:0]  width_r;
  logic [CFG_HEIGHT_W-1:0] height_r;
  logic                    cfg_write;
  reg_idx_t                cfg_idx;
  logic [WU_W-1:0]         w_use;
  logic [HU_W-1:0]         h_use;

  // Position
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] c_pre, c_cur;
  logic [ROW_W-1:0] r_pre, r_cur;
  logic [ROW_W:0]   r_inc, r_next1;
  logic [COL_W:0]   c_next1;
  logic             c_wrap;
  logic [ROW_W+CROW_W-1:0] crow_x;
  logic [COL_W+CCOL_W-1:0] ccol_x;
  meta_t            meta_cur;
  logic             emit_cur;

  // Pipeline
  logic             en;
  logic             in_fire;
  logic             s1_v_r;
  pix_t             s1_px_r;
  logic [1:0]       s1_slot_r;
  logic             s1_emit_r;
  meta_t            s1_meta_r;
  pix_t             ram_rd [NSLOT];
  pix_t             col_new [KSIZE];
  win_t             win_r, win_nxt;
  logic             s2_v_r;
  meta_t            s2_meta_r;

  // Results
  logic                res_v;
  logic [SMOOTH_W-1:0] res_smoothed;
  meta_t               res_meta;
  logic                out_v_r;
  logic [SMOOTH_W-1:0] out_smoothed_r;
  meta_t               out_meta_r;
  logic                skid_v_r;
  logic [SMOOTH_W-1:0] skid_smoothed_r;
  meta_t               skid_meta_r;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_WIDTH_W'(WIDTH_RESET);
      height_r <= CFG_HEIGHT_W'(HEIGHT_RESET);
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  width_r  <= cfg_pwdata[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_pwdata[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:  cfg_prdata = APB_DATA_W'(width_r);
      REG_IMAGE_HEIGHT: cfg_prdata = APB_DATA_W'(height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // Geometry in use is the register clamped to the supported range.
  always_comb begin
    if (WU_W'(width_r) < WU_W'(MIN_DIM)) begin
      w_use = WU_W'(MIN_DIM);
    end else if (WU_W'(width_r) > WU_W'(MAX_WIDTH)) begin
      w_use = WU_W'(MAX_WIDTH);
    end else begin
      w_use = WU_W'(width_r);
    end
    if (HU_W'(height_r) < HU_W'(MIN_DIM)) begin
      h_use = HU_W'(MIN_DIM);
    end else if (HU_W'(height_r) > HU_W'(MAX_HEIGHT)) begin
      h_use = HU_W'(MAX_HEIGHT);
    end else begin
      h_use = HU_W'(height_r);
    end
  end

  // ---------------- position of the incoming pixel ----------------
  assign en        = !skid_v_r;
  assign in_tready = en;
  assign in_fire   = in_tvalid && en;

  always_comb begin
    c_pre  = in_tuser[0] ? '0 : col_r;
    r_pre  = in_tuser[0] ? '0 : row_r;
    // A column past a shrunken width starts the next row.
    c_wrap = WU_W'(c_pre) >= w_use;
    c_cur  = c_wrap ? '0 : c_pre;
    r_inc  = {1'b0, r_pre} + (ROW_W + 1)'(c_wrap);
    r_cur  = (HU_W'(r_inc) >= h_use) ? '0 : r_inc[ROW_W-1:0];

    c_next1 = {1'b0, c_cur} + 1'b1;
    r_next1 = {1'b0, r_cur} + 1'b1;
    if (WU_W'(c_next1) >= w_use) begin
      col_nxt = '0;
      row_nxt = (HU_W'(r_next1) >= h_use) ? '0 : r_next1[ROW_W-1:0];
    end else begin
      col_nxt = c_next1[COL_W-1:0];
      row_nxt = r_cur;
    end

    emit_cur      = (r_cur >= ROW_W'(KSIZE - 1)) && (c_cur >= COL_W'(KSIZE - 1));
    crow_x        = (ROW_W + CROW_W)'(r_cur) - (ROW_W + CROW_W)'(2);
    ccol_x        = (COL_W + CCOL_W)'(c_cur) - (COL_W + CCOL_W)'(2);
    meta_cur.crow = crow_x[CROW_W-1:0];
    meta_cur.ccol = ccol_x[CCOL_W-1:0];
    meta_cur.last = (HU_W'(r_cur) == h_use - 1'b1) && (WU_W'(c_cur) == w_use - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- line stores: slot k holds rows with row mod 4 == k ----------------
  for (genvar k = 0; k < NSLOT; k++) begin : g_line
    gs5_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .en    (in_fire),
      .we    (r_cur[1:0] == 2'(k)),
      .addr  (c_cur),
      .wdata (in_tdata[PIXEL_W-1:0]),
      .rdata (ram_rd[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_fire;
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r   <= in_tdata[PIXEL_W-1:0];
      s1_slot_r <= r_cur[1:0];
      s1_emit_r <= emit_cur;
      s1_meta_r <= meta_cur;
    end
  end

  // The slot of the item's own row still reads the row four above (read-first RAM).
  always_comb begin
    for (int i = 0; i < NSLOT; i++) begin
      col_new[i] = ram_rd[2'(s1_slot_r + 2'(i))];
    end
    col_new[KSIZE-1] = s1_px_r;
    for (int i = 0; i < KSIZE; i++) begin
      for (int j = 0; j < KSIZE - 1; j++) begin
        win_nxt[i][j] = win_r[i][j+1];
      end
      win_nxt[i][KSIZE-1] = col_new[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_v_r) begin
      win_r     <= win_nxt;
      s2_meta_r <= s1_meta_r;
    end
  end

  gs5_kernel u_kernel (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (s2_v_r),
    .in_win       (win_r),
    .in_meta      (s2_meta_r),
    .out_valid    (res_v),
    .out_smoothed (res_smoothed),
    .out_meta     (res_meta)
  );

  // ---------------- output register and skid register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (res_v) begin
      if (out_v_r && !out_tready) begin
        skid_v_r <= 1'b1;
      end
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_smoothed_r <= skid_smoothed_r;
        out_meta_r     <= skid_meta_r;
      end
    end else if (res_v) begin
      if (!out_v_r || out_tready) begin
        out_smoothed_r <= res_smoothed;
        out_meta_r     <= res_meta;
      end else begin
        skid_smoothed_r <= res_smoothed;
        skid_meta_r     <= res_meta;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_meta_r.ccol, out_meta_r.crow, out_smoothed_r};
  assign out_tlast  = out_meta_r.last;

  `GS5_ASSERT_IMP(a_skid_behind_out, skid_v_r, out_v_r)
  `GS5_ASSERT_NXT(a_skid_fill, !skid_v_r && res_v && out_v_r && !out_tready, skid_v_r)
  `GS5_ASSERT_NXT(a_frame_start, in_fire && in_tuser[0], (col_r == COL_W'(1)) && (row_r == '0))

endmodule
`default_nettype wire

// ===== bench/gaussian_5x5_smoothing_checker.sv =====
`timescale 1ns / 100ps
// Watches the pixel, result and register channels, predicts each smoothed item and compares it.
module gaussian_5x5_smoothing_checker
  import gs5_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [7:0]            in_tdata,   // [7:0] pixel
  input  wire logic [0:0]            in_tuser,   // [0] frame_start
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [39:0]           out_tdata,  // [15:0] smoothed, [27:16] center_row,
                                                 // [38:28] center_col, [39] zero
  input  wire logic                  out_tlast,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic [APB_DATA_W-1:0] cfg_pwdata,
  input  wire logic                  cfg_pready,
  output int unsigned                pending_results,
  output int unsigned                mismatch_count
);

  localparam int unsigned LINE_ROWS    = 4;

  // Kernel taps in raster order, oldest row first.
  localparam logic [0:24][3:0] GAUSS_TAPS = {
    4'd2, 4'd4,  4'd5,  4'd4,  4'd2,
    4'd4, 4'd9,  4'd12, 4'd9,  4'd4,
    4'd5, 4'd12, 4'd15, 4'd12, 4'd5,
    4'd4, 4'd9,  4'd12, 4'd9,  4'd4,
    4'd2, 4'd4,  4'd5,  4'd4,  4'd2
  };

  typedef struct packed {
    logic [SMOOTH_W-1:0] smoothed;
    logic [CROW_W-1:0]   center_row;
    logic [CCOL_W-1:0]   center_col;
    logic                last;
  } smooth_result_t;

  logic [PIXEL_W-1:0]      line_mem [LINE_ROWS*GS5_MAX_WIDTH];
  logic [PIXEL_W-1:0]      win [KSIZE][KSIZE];
  logic [CFG_WIDTH_W-1:0]  width_reg;
  logic [CFG_HEIGHT_W-1:0] height_reg;
  int unsigned             row_pos;
  int unsigned             col_pos;
  int unsigned             fail_total = 0;
  smooth_result_t          smooth_q[$];

  task automatic predict_item(input logic [PIXEL_W-1:0] px, input logic frame_start);
    int unsigned w;
    int unsigned h;
    int unsigned acc;
    int unsigned i;
    int unsigned j;
    smooth_result_t res;
    w = width_reg;
    h = height_reg;
    if (w < MIN_DIM) w = MIN_DIM;
    else if (w > GS5_MAX_WIDTH) w = GS5_MAX_WIDTH;
    if (h < MIN_DIM) h = MIN_DIM;
    else if (h > GS5_MAX_HEIGHT) h = GS5_MAX_HEIGHT;

    if (frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    // A geometry that shrank since the last item moves the position on first.
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;

    for (i = 0; i < KSIZE; i++) begin
      for (j = 0; j < KSIZE - 1; j++) win[i][j] = win[i][j+1];
      if (i < KSIZE - 1) win[i][KSIZE-1] = line_mem[((row_pos + i) % LINE_ROWS) * GS5_MAX_WIDTH
                                                    + col_pos];
    end
    win[KSIZE-1][KSIZE-1] = px;
    line_mem[(row_pos % LINE_ROWS) * GS5_MAX_WIDTH + col_pos] = px;

    if (row_pos >= KSIZE - 1 && col_pos >= KSIZE - 1) begin
      acc = 0;
      for (i = 0; i < KSIZE; i++) begin
        for (j = 0; j < KSIZE; j++) acc += GAUSS_TAPS[i*KSIZE+j] * win[i][j];
      end
      res.smoothed   = SMOOTH_W'((acc * 512 + 159) / 318);
      res.center_row = CROW_W'(row_pos - 2);
      res.center_col = CCOL_W'(col_pos - 2);
      res.last       = (row_pos == h - 1) && (col_pos == w - 1);
      smooth_q.push_back(res);
    end

    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_total++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    smooth_result_t want;
    int unsigned i;
    int unsigned j;
    if (!rst_n) begin
      for (i = 0; i < KSIZE; i++) begin
        for (j = 0; j < KSIZE; j++) win[i][j] = '0;
      end
      row_pos    = 0;
      col_pos    = 0;
      width_reg  = CFG_WIDTH_W'(WIDTH_RESET);
      height_reg = CFG_HEIGHT_W'(HEIGHT_RESET);
      smooth_q.delete();
    end else begin
      // A pixel taken at the same edge as a register write still sees the old geometry.
      if (in_tvalid && in_tready) predict_item(in_tdata, in_tuser[0]);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[2]))
          REG_IMAGE_WIDTH:  width_reg  = cfg_pwdata[CFG_WIDTH_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = cfg_pwdata[CFG_HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (smooth_q.size() == 0) begin
          fail_total++;
          $display("%0t: unexpected result item, expected none, actual data %h last %b",
                   $time, out_tdata, out_tlast);
        end else begin
          want = smooth_q.pop_front();
          check_field("smoothed", 32'(want.smoothed), 32'(out_tdata[15:0]));
          check_field("center_row", 32'(want.center_row), 32'(out_tdata[27:16]));
          check_field("center_col", 32'(want.center_col), 32'(out_tdata[38:28]));
          check_field("tdata pad", 32'(1'b0), 32'(out_tdata[39]));
          check_field("last", 32'(want.last), 32'(out_tlast));
        end
      end
    end
    pending_results <= smooth_q.size();
    mismatch_count  <= fail_total;
  end

endmodule

// ===== bench/gaussian_5x5_smoothing_test.sv =====
`timescale 1ns / 100ps
// Drives frames and register writes into the Gaussian smoothing block and reports the verdict.
module gaussian_5x5_smoothing_test;
  import gs5_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 360;
  localparam int unsigned DRAIN_LIMIT   = 100000;
  localparam int unsigned LATENCY_SLACK = 12;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata    = '0;   // [7:0] pixel
  logic [0:0]            in_tuser    = '0;   // [0] frame_start
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [39:0]           out_tdata;          // [15:0] smoothed, [27:16] center_row,
                                             // [38:28] center_col, [39] zero
  logic                  out_tlast;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr   = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata  = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int unsigned pending_results;
  int unsigned mismatch_count;
  int unsigned burst_left = 0;
  int unsigned act_w      = WIDTH_RESET;

  gaussian_5x5_smoothing u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  gaussian_5x5_smoothing_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_pready      (cfg_pready),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("gaussian_5x5_smoothing_test: FAIL");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned active_dim(input int unsigned raw, input int unsigned limit);
    if (raw < MIN_DIM) return MIN_DIM;
    if (raw > limit) return limit;
    return raw;
  endfunction

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] field, input int unsigned bits);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= APB_ADDR_W'({idx, 2'b00});
    // Bits above the register are filled with noise; the block must ignore them.
    cfg_pwdata  <= (32'($urandom) << bits) | field;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Writes both geometry registers and tells whether the width in use grew.
  task automatic program_geometry(input int unsigned wr, input int unsigned hr,
                                  output logic grew);
    int unsigned nw;
    nw = active_dim(wr, GS5_MAX_WIDTH);
    apb_write(REG_IMAGE_WIDTH, wr, CFG_WIDTH_W);
    apb_write(REG_IMAGE_HEIGHT, hr, CFG_HEIGHT_W);
    grew  = nw > act_w;
    act_w = nw;
  endtask

  task automatic push_pixel(input logic [7:0] px, input logic fs);
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(16, 64);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_pixels(input int unsigned count, input logic start, input logic stray);
    int unsigned k;
    logic [7:0] px;
    logic fs;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 7))
        0:       px = 8'h00;
        1:       px = 8'hFF;
        default: px = 8'($urandom);
      endcase
      if (k == 0) fs = start;
      else fs = stray && ($urandom_range(0, 99) == 0);
      push_pixel(px, fs);
    end
  endtask

  // Waits until every predicted item has come out and the pipeline has drained.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  initial begin : ready_gen
    int unsigned hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = idle_len();
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      hold = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      repeat (hold) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned n;
    int unsigned k;
    int unsigned wr;
    int unsigned hr;
    logic grew;
    logic start;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest frame: one all-white frame, then an all-black one that follows on
    // from the counter wrap at end of frame, without a frame start.
    program_geometry(MIN_DIM, MIN_DIM, grew);
    for (k = 0; k < MIN_DIM * MIN_DIM; k++) push_pixel(8'hFF, k == 0);
    for (k = 0; k < MIN_DIM * MIN_DIM; k++) push_pixel(8'h00, 1'b0);
    settle();

    // Small random frames. Some phases carry on mid-frame under a narrower or
    // shorter geometry; a wider one always restarts the frame.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12);
      hr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 9);
      program_geometry(wr, hr, grew);
      start = grew || ($urandom_range(0, 1) == 0);
      n = act_w * active_dim(hr, GS5_MAX_HEIGHT);
      if ($urandom_range(0, 2) == 0) n = $urandom_range(1, n);
      send_pixels(n, start, 1'b1);
      sent += n;
      settle();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    for (n = 0; n < DRAIN_LIMIT && pending_results != 0; n++) @(posedge clk);
    repeat (LATENCY_SLACK) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("gaussian_5x5_smoothing_test: PASS");
    end else begin
      $display("gaussian_5x5_smoothing_test: FAIL");
    end
    $finish;
  end

endmodule
